// ----- rtl/core/shell_cartesian_to_spherical_unit_defines.svh -----
// Assertion helpers for the shell converter.
`ifndef SHELL_CARTESIAN_TO_SPHERICAL_UNIT_DEFINES_SVH
`define SHELL_CARTESIAN_TO_SPHERICAL_UNIT_DEFINES_SVH

// Clocked on clk_i, off while in reset.
`define SC2S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked during reset.
`define SC2S_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/sc2s_pkg.sv -----
package sc2s_pkg;

  localparam int unsigned CORDIC_STAGES = 28;

  // CORDIC datapath widths
  localparam int unsigned XW = 38;  // x/y working width
  localparam int unsigned AW = 32;  // angle accumulator, Q3.28 signed
  localparam int unsigned MW = 34;  // scaled magnitude, Q18.16

  localparam logic signed [AW-1:0] PI_Q28         = 32'sd843314857;
  localparam logic signed [AW-1:0] HALF_PI_Q28    = 32'sd421657428;
  localparam logic signed [AW-1:0] QUARTER_PI_Q28 = 32'sd210828714;
  localparam logic [31:0]          INV_GAIN_Q32   = 32'd2608131496;

  // boundary codes
  localparam logic [1:0] BND_INNER = 2'd1;
  localparam logic [1:0] BND_OUTER = 2'd2;

  // register indexes
  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_CENTER_Z   = 3'd2;
  localparam logic [2:0] REG_HALF_WIDTH = 3'd3;
  localparam logic [2:0] REG_MID_RADIUS = 3'd4;
  localparam logic [2:0] REG_INV_HALF   = 3'd5;
  localparam logic [2:0] REG_TOLERANCE  = 3'd6;

  // data that rides alongside a CORDIC pass
  typedef struct packed {
    logic signed [32:0]    dz;
    logic signed [AW-1:0]  az;
    logic [1:0]            bnd;
    logic                  axis;
  } side_t;

  // round(atan(2^-i) * 2^28)
  function automatic logic signed [AW-1:0] atan_step(int unsigned i);
    logic signed [AW-1:0] a;
    a = '0;
    case (i)
      0: a = QUARTER_PI_Q28;
      1: a = 32'sd124459457;
      2: a = 32'sd65760959;
      3: a = 32'sd33381290;
      4: a = 32'sd16755422;
      5: a = 32'sd8385879;
      6: a = 32'sd4193963;
      7: a = 32'sd2097109;
      8: a = 32'sd1048571;
      9: a = 32'sd524287;
      29: a = 32'sd1;
      default: begin
        if (i >= 10 && i <= 28) a = 32'sd1 <<< (28 - i);
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/shell_cartesian_to_spherical_unit.sv -----
// Channel   Dir  Contents
// s_axis    in   tdata: pos_x, pos_y, pos_z; tuser: boundary
// m_axis    out  tdata: radial_coord, polar_angle, azimuth, in_shell, saturated
// cfg       in   one register write per cycle while cfg_we_i is high
//
// One point per cycle sustained while the output is not stalled; two CORDIC
// vectoring pipelines in series, each fold + stages + gain.
// Reset clears all valid bits and loads the register defaults.
// When the output holds an untaken result the whole pipeline freezes;
// nothing is dropped or repeated, and s_axis_tready drops only then.
module shell_cartesian_to_spherical_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
  input  logic [1:0]  s_axis_tuser,   // boundary[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // radial[31:0], polar[61:32], azimuth[92:62],
                                      // in_shell[93], saturated[94], zero[95]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import sc2s_pkg::*;
  `include "shell_cartesian_to_spherical_unit_defines.svh"

  // ---------------- configuration ----------------
  logic signed [31:0] cen_x_q, cen_y_q, cen_z_q;
  logic [30:0]        half_q, mid_q;
  logic [31:0]        inv_q;
  logic [15:0]        tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_x_q <= '0;
      cen_y_q <= '0;
      cen_z_q <= '0;
      half_q  <= 31'd65536;
      mid_q   <= 31'd131072;
      inv_q   <= 32'd65536;
      tol_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X:   cen_x_q <= cfg_data_i;
        REG_CENTER_Y:   cen_y_q <= cfg_data_i;
        REG_CENTER_Z:   cen_z_q <= cfg_data_i;
        REG_HALF_WIDTH: half_q  <= cfg_data_i[30:0];
        REG_MID_RADIUS: mid_q   <= cfg_data_i[30:0];
        REG_INV_HALF:   inv_q   <= cfg_data_i;
        REG_TOLERANCE:  tol_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- global stall ----------------
  logic out_v_q;
  logic en;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 0: centre offset ----------------
  logic               p0_v_q;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic [1:0]         bnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p0_v_q <= 1'b0;
    else if (en) p0_v_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= 33'(signed'(s_axis_tdata[31:0])) - 33'(cen_x_q);
      dy_q  <= 33'(signed'(s_axis_tdata[63:32])) - 33'(cen_y_q);
      dz_q  <= 33'(signed'(s_axis_tdata[95:64])) - 33'(cen_z_q);
      bnd_q <= s_axis_tuser;
    end
  end

  // ---------------- CORDIC on (x,y): rho and azimuth ----------------
  side_t                c1_side, c1_side_o, c2_side, c2_side_o;
  logic                 c1_v, c2_v;
  logic [MW-1:0]        rho, r_mag;
  logic signed [AW-1:0] az_ang, pol_ang;

  always_comb begin
    c1_side      = '0;
    c1_side.dz   = dz_q;
    c1_side.bnd  = bnd_q;
    c1_side.axis = (dx_q == '0) && (dy_q == '0);
  end

  // on the axis (0,0) runs through and yields rho = 0
  sc2s_cordic u_cordic_xy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p0_v_q),
    .x_i     (XW'(dx_q)),
    .y_i     (XW'(dy_q)),
    .side_i  (c1_side),
    .valid_o (c1_v),
    .mag_o   (rho),
    .ang_o   (az_ang),
    .side_o  (c1_side_o)
  );

  always_comb begin
    c2_side    = c1_side_o;
    c2_side.az = az_ang;
  end

  // ---------------- CORDIC on (z,rho): r and polar angle ----------------
  sc2s_cordic u_cordic_zr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c1_v),
    .x_i     (XW'(c1_side_o.dz)),
    .y_i     (signed'({{(XW-MW){1'b0}}, rho})),
    .side_i  (c2_side),
    .valid_o (c2_v),
    .mag_o   (r_mag),
    .ang_o   (pol_ang),
    .side_o  (c2_side_o)
  );

  // ---------------- R1: offset from mid radius, angle clamps ----------------
  logic               r1_v_q, r1_neg_q, r1_inner_pos_q;
  logic [34:0]        r1_mag_q;
  logic [29:0]        r1_pol_q;
  logic [30:0]        r1_az_q;
  logic [1:0]         r1_bnd_q;
  logic [MW-1:0]      r1_r_q;
  logic [48:0]        r1_outer_q;
  logic [47:0]        r1_inner_q;

  logic signed [35:0] d_d;
  logic signed [32:0] inner_d;
  logic [31:0]        outer_d;
  logic signed [AW-1:0] pol_d, az_d;

  assign d_d     = signed'({2'b00, r_mag}) - signed'({5'b00000, mid_q});
  assign inner_d = signed'({2'b00, mid_q}) - signed'({2'b00, half_q});
  assign outer_d = 32'(half_q) + 32'(mid_q);

  always_comb begin
    pol_d = pol_ang;
    if (pol_d < 0) pol_d = '0;
    if (pol_d > PI_Q28) pol_d = PI_Q28;
    az_d = c2_side_o.az;
    if (az_d < -PI_Q28) az_d = -PI_Q28;
    if (az_d > PI_Q28) az_d = PI_Q28;
    if (c2_side_o.axis) begin
      pol_d = c2_side_o.dz[32] ? PI_Q28 : '0;
      az_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r1_v_q <= 1'b0;
    else if (en) r1_v_q <= c2_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_neg_q       <= d_d[35];
      r1_mag_q       <= d_d[35] ? 35'(-d_d) : d_d[34:0];
      r1_pol_q       <= pol_d[29:0];
      r1_az_q        <= az_d[30:0];
      r1_bnd_q       <= c2_side_o.bnd;
      r1_r_q         <= r_mag;
      r1_outer_q     <= 49'(outer_d) * 49'(17'd65536 + 17'(tol_q));
      r1_inner_pos_q <= !inner_d[32] && (inner_d != '0);
      r1_inner_q     <= 48'(inner_d[30:0]) * 48'(17'd65536 - 17'(tol_q));
    end
  end

  // ---------------- R2: radial partial products, shell test ----------------
  logic        r2_v_q, r2_neg_q, r2_ok_q;
  logic [50:0] r2_ph_q;
  logic [48:0] r2_pl_q;
  logic [29:0] r2_pol_q;
  logic [30:0] r2_az_q;
  logic [1:0]  r2_bnd_q;
  logic [49:0] rs_d;

  assign rs_d = {r1_r_q, 16'h0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r2_v_q <= 1'b0;
    else if (en) r2_v_q <= r1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_neg_q <= r1_neg_q;
      r2_ph_q  <= 51'(r1_mag_q[34:16]) * 51'(inv_q);
      r2_pl_q  <= 49'(r1_mag_q[15:0]) * 49'(inv_q) + 49'h8000;
      r2_ok_q  <= (rs_d <= 50'(r1_outer_q)) &&
                  (!r1_inner_pos_q || (rs_d >= 50'(r1_inner_q)));
      r2_pol_q <= r1_pol_q;
      r2_az_q  <= r1_az_q;
      r2_bnd_q <= r1_bnd_q;
    end
  end

  // ---------------- R3: output register ----------------
  logic [51:0]        prod_d;
  logic signed [31:0] radial_d, radial_q;
  logic               sat_d, sat_q;
  logic [29:0]        pol_q;
  logic [30:0]        az_q;
  logic               ok_q;

  assign prod_d = 52'(r2_ph_q) + 52'(r2_pl_q >> 16);

  always_comb begin
    sat_d = 1'b0;
    if (r2_neg_q) begin
      if (prod_d > 52'd2147483648) begin
        sat_d    = 1'b1;
        radial_d = 32'sh8000_0000;
      end else begin
        radial_d = -signed'(prod_d[31:0]);
      end
    end else begin
      if (prod_d > 52'd2147483647) begin
        sat_d    = 1'b1;
        radial_d = 32'sh7FFF_FFFF;
      end else begin
        radial_d = signed'(prod_d[31:0]);
      end
    end
    case (r2_bnd_q)
      BND_INNER: begin
        radial_d = -32'sd65536;
        sat_d    = 1'b0;
      end
      BND_OUTER: begin
        radial_d = 32'sd65536;
        sat_d    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= r2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      radial_q <= radial_d;
      sat_q    <= sat_d;
      pol_q    <= r2_pol_q;
      az_q     <= r2_az_q;
      ok_q     <= r2_ok_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, sat_q, ok_q, az_q, pol_q, radial_q};

  // ---------------- checks ----------------
  `SC2S_ASSERT(a_sat_clip, out_v_q && sat_q |-> (radial_q == 32'sh7FFF_FFFF || radial_q == 32'sh8000_0000), "saturated without clipped radial")
  `SC2S_ASSERT(a_pol_range, out_v_q |-> (32'(pol_q) <= 32'(PI_Q28)), "polar angle above pi")
  `SC2S_ASSERT(a_freeze, !en |=> ($stable(r1_v_q) && $stable(r2_v_q) && $stable(p0_v_q)), "pipeline moved while stalled")
  `SC2S_ASSERT_ALWAYS(a_rdy, !rst_ni || !m_axis_tready || s_axis_tready, "not ready while output drains")

endmodule

// ----- rtl/core/sc2s_cordic.sv -----
module sc2s_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [sc2s_pkg::XW-1:0] x_i,
  input  logic signed [sc2s_pkg::XW-1:0] y_i,
  input  sc2s_pkg::side_t              side_i,
  output logic                         valid_o,
  output logic [sc2s_pkg::MW-1:0]      mag_o,
  output logic signed [sc2s_pkg::AW-1:0] ang_o,
  output sc2s_pkg::side_t              side_o
);
  import sc2s_pkg::*;

  localparam int unsigned N = CORDIC_STAGES;

  logic                 v_q  [N+1];
  logic signed [XW-1:0] x_q  [N+1];
  logic signed [XW-1:0] y_q  [N+1];
  logic signed [AW-1:0] z_q  [N+1];
  side_t                sd_q [N+1];

  logic signed [XW-1:0] x0_d, y0_d;
  logic signed [AW-1:0] z0_d;

  // quadrant fold: left half plane turned by -/+ pi/2
  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    z0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d = y_i;
        y0_d = -x_i;
        z0_d = HALF_PI_Q28;
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        z0_d = -HALF_PI_Q28;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= x0_d;
      y_q[0]  <= y0_d;
      z_q[0]  <= z0_d;
      sd_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN_I = atan_step(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (en_i) v_q[i+1] <= v_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_I;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_I;
        end
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  // gain correction, split at bit 16 into two partial products
  logic                 sa_v_q, sb_v_q;
  logic [51:0]          ph_q;
  logic [48:0]          pl_q;
  logic signed [AW-1:0] sa_ang_q;
  side_t                sa_side_q;
  logic [MW-1:0]        mag_q;
  logic signed [AW-1:0] ang_q;
  side_t                side_q;
  logic [51:0]          sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
      sb_v_q <= 1'b0;
    end else if (en_i) begin
      sa_v_q <= v_q[N];
      sb_v_q <= sa_v_q;
    end
  end

  assign sum_d = ph_q + 52'(pl_q >> 16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q      <= 52'(x_q[N][35:16]) * 52'(INV_GAIN_Q32);
      pl_q      <= 49'(x_q[N][15:0]) * 49'(INV_GAIN_Q32) + 49'h0_8000_0000;
      sa_ang_q  <= z_q[N];
      sa_side_q <= sd_q[N];
      mag_q     <= sum_d[MW+15:16];
      ang_q     <= sa_ang_q;
      side_q    <= sa_side_q;
    end
  end

  assign valid_o = sb_v_q;
  assign mag_o   = mag_q;
  assign ang_o   = ang_q;
  assign side_o  = side_q;

endmodule
